>>> hdl/pfa_pkg.sv
// Shared constants, codes and control structs of the page frame allocator.
`default_nettype none
package pfa_pkg;
  localparam int unsigned FRAMES    = 64;
  localparam int unsigned FRAME_W   = $clog2(FRAMES);
  localparam int unsigned FIDX_W    = FRAME_W + 1;
  localparam int unsigned PROCS     = 8;
  localparam int unsigned PID_W     = 3;
  localparam int unsigned MAX_PAGES = 16;
  localparam int unsigned PAGE_W    = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W     = PAGE_W + 1;
  localparam int unsigned MEM_AW    = PID_W + PAGE_W;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned SIZE_W  = 20;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned PHYS_W  = 18;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 32;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd3;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_RESIZE = 2'd1;
  localparam logic [OP_W-1:0] OP_XLATE  = 2'd2;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_TABLE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_OOM       = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNMAPPED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_CHANGE = 3'd4;
  localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd5;

  localparam logic CFG_PAGE_SHIFT  = 1'b0;
  localparam logic CFG_FRAME_LIMIT = 1'b1;

  typedef enum logic [1:0] {DEC_RESPOND, DEC_COUNT, DEC_DROP, DEC_XLATE} dec_e;

  typedef struct packed {
    logic load;
    logic decide;
    logic cnt_step;
    logic grab_init;
    logic grab_step;
    logic oom;
    logic drop_rd;
    logic drop_clr;
    logic xl_rd;
    logic xl_fin;
    logic commit_grow;
    logic commit_drop;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    dec_e dec;
    logic scan_end;
    logic enough;
    logic grab_done;
    logic drop_done;
  } dp_sts_t;
endpackage
`default_nettype wire

>>> hdl/pfa_ctrl.sv
// Operation sequencer of the page frame allocator.
`default_nettype none
module pfa_ctrl import pfa_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o,
  output logic         idle_o
);
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_COUNT    = 4'd2;
  localparam logic [3:0] S_GRAB     = 4'd3;
  localparam logic [3:0] S_DROP_RD  = 4'd4;
  localparam logic [3:0] S_DROP_CLR = 4'd5;
  localparam logic [3:0] S_XL_RD    = 4'd6;
  localparam logic [3:0] S_XL_FIN   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        case (sts_i.dec)
          DEC_COUNT: state_d = S_COUNT;
          DEC_DROP:  state_d = S_DROP_RD;
          DEC_XLATE: state_d = S_XL_RD;
          default:   state_d = S_DONE;
        endcase
      end
      S_COUNT: begin
        if (!sts_i.scan_end) begin
          cmd_o.cnt_step = 1'b1;
        end else if (sts_i.enough) begin
          cmd_o.grab_init = 1'b1;
          state_d         = S_GRAB;
        end else begin
          cmd_o.oom = 1'b1;
          state_d   = S_DONE;
        end
      end
      S_GRAB: begin
        if (sts_i.grab_done || sts_i.scan_end) begin
          cmd_o.commit_grow = 1'b1;
          state_d           = S_DONE;
        end else begin
          cmd_o.grab_step = 1'b1;
        end
      end
      S_DROP_RD: begin
        if (sts_i.drop_done) begin
          cmd_o.commit_drop = 1'b1;
          state_d           = S_DONE;
        end else begin
          cmd_o.drop_rd = 1'b1;
          state_d       = S_DROP_CLR;
        end
      end
      S_DROP_CLR: begin
        cmd_o.drop_clr = 1'b1;
        state_d        = S_DROP_RD;
      end
      S_XL_RD: begin
        cmd_o.xl_rd = 1'b1;
        state_d     = S_XL_FIN;
      end
      S_XL_FIN: begin
        cmd_o.xl_fin = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign idle_o = (state_q == S_IDLE);
endmodule
`default_nettype wire

>>> hdl/pfa_dp.sv
// Datapath: frame bitmap, page tables, scan counters and result registers.
`default_nettype none
module pfa_dp import pfa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  output dp_sts_t                 sts_o,
  input  wire logic [OP_W-1:0]    opcode_i,
  input  wire logic [PID_W-1:0]   pid_i,
  input  wire logic [SIZE_W-1:0]  size_bytes_i,
  input  wire logic [ADDR_W-1:0]  logical_address_i,
  input  wire logic [SHIFT_W-1:0] page_shift_i,
  input  wire logic [LIMIT_W-1:0] frame_limit_i,
  output logic [STAT_W-1:0]       status_o,
  output logic [PHYS_W-1:0]       physical_address_o,
  output logic [CNT_W-1:0]        page_count_o
);
  logic [FRAMES-1:0]  frame_used_q;
  logic [CNT_W-1:0]   held_q [PROCS];
  logic [PROCS-1:0]   present_q;
  logic [FRAME_W-1:0] page_frame_mem [PROCS*MAX_PAGES];
  logic [FRAME_W-1:0] rd_data_q;

  logic [OP_W-1:0]    op_q;
  logic [PID_W-1:0]   pid_q;
  logic [SIZE_W-1:0]  size_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [SHIFT_W-1:0] sh_q;
  logic [11:0]        mask_q;
  logic [FIDX_W-1:0]  lim_q;
  logic [CNT_W-1:0]   need_q;
  logic               need_big_q;
  logic [FIDX_W-1:0]  idx_q;
  logic [FIDX_W-1:0]  cnt_q;
  logic [CNT_W-1:0]   pg_q;
  logic [STAT_W-1:0]  res_status_q;
  logic [PHYS_W-1:0]  res_phys_q;
  logic [CNT_W-1:0]   res_count_q;

  // Item setup: clamped shift, effective limit and pages needed.
  logic [SHIFT_W-1:0] sh_w;
  logic [11:0]        mask_w;
  logic [SIZE_W:0]    need_full_w;
  logic [FIDX_W-1:0]  lim_w;

  always_comb begin
    if (page_shift_i < SHIFT_MIN) sh_w = SHIFT_MIN;
    else if (page_shift_i > SHIFT_MAX) sh_w = SHIFT_MAX;
    else sh_w = page_shift_i;
    mask_w      = 12'((13'd1 << sh_w) - 13'd1);
    need_full_w = ({1'b0, size_bytes_i} + {9'd0, mask_w}) >> sh_w;
    lim_w = (frame_limit_i > LIMIT_W'(FRAMES)) ? FIDX_W'(FRAMES) : FIDX_W'(frame_limit_i);
  end

  // Decision on the latched item.
  logic [CNT_W-1:0]  held_w;
  logic              has_w;
  logic [SIZE_W:0]   cur_bytes_w;
  logic [12:0]       xl_page_w;
  dec_e              dec_w;
  logic [STAT_W-1:0] d_status_w;
  logic [CNT_W-1:0]  d_count_w;
  logic [CNT_W-1:0]  d_first_w;
  logic [CNT_W-1:0]  target_w;

  always_comb begin
    held_w      = held_q[pid_q];
    has_w       = present_q[pid_q];
    cur_bytes_w = {{(SIZE_W+1-CNT_W){1'b0}}, held_w} << sh_q;
    xl_page_w   = 13'(addr_q >> sh_q);
    dec_w       = DEC_RESPOND;
    d_status_w  = ST_DONE;
    d_count_w   = '0;
    d_first_w   = '0;
    if (op_q == OP_CREATE) begin
      if (has_w) begin
        d_status_w = ST_EXISTS;
        d_count_w  = held_w;
      end else if (need_big_q) begin
        d_status_w = ST_OOM;
      end else begin
        dec_w = DEC_COUNT;
      end
    end else if (!has_w) begin
      d_status_w = ST_NO_TABLE;
    end else begin
      d_count_w = held_w;
      case (op_q)
        OP_RESIZE: begin
          if ({1'b0, size_q} == cur_bytes_w) begin
            d_status_w = ST_NO_CHANGE;
          end else if ({1'b0, size_q} > cur_bytes_w) begin
            if (need_big_q) d_status_w = ST_OOM;
            else begin
              dec_w     = DEC_COUNT;
              d_first_w = held_w;
            end
          end else begin
            dec_w     = DEC_DROP;
            d_first_w = need_q;
          end
        end
        OP_XLATE: begin
          if (xl_page_w >= {8'd0, held_w}) d_status_w = ST_UNMAPPED;
          else dec_w = DEC_XLATE;
        end
        default: begin
          dec_w     = DEC_DROP;
          d_count_w = '0;
        end
      endcase
    end
    target_w = (op_q == OP_CREATE) ? need_q : CNT_W'(need_q - held_w);
  end

  logic free_here_w;
  assign free_here_w = (idx_q < lim_q) && !frame_used_q[idx_q[FRAME_W-1:0]];

  assign sts_o.dec       = dec_w;
  assign sts_o.scan_end  = (idx_q == FIDX_W'(FRAMES));
  assign sts_o.enough    = (cnt_q >= {{(FIDX_W-CNT_W){1'b0}}, target_w});
  assign sts_o.grab_done = (pg_q == need_q);
  assign sts_o.drop_done = (pg_q == held_w);

  logic [MEM_AW-1:0] mem_addr_w;
  assign mem_addr_w = {pid_q, pg_q[PAGE_W-1:0]};

  // Page table memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.grab_step && free_here_w) begin
      page_frame_mem[mem_addr_w] <= idx_q[FRAME_W-1:0];
    end
    if (cmd_i.drop_rd) begin
      rd_data_q <= page_frame_mem[mem_addr_w];
    end else if (cmd_i.xl_rd) begin
      rd_data_q <= page_frame_mem[{pid_q, xl_page_w[PAGE_W-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= opcode_i;
      pid_q      <= pid_i;
      size_q     <= size_bytes_i;
      addr_q     <= logical_address_i;
      sh_q       <= sh_w;
      mask_q     <= mask_w;
      lim_q      <= lim_w;
      need_q     <= need_full_w[CNT_W-1:0];
      need_big_q <= (need_full_w > (SIZE_W+1)'(MAX_PAGES));
    end
    if (cmd_i.decide) begin
      idx_q        <= '0;
      cnt_q        <= '0;
      pg_q         <= d_first_w;
      res_status_q <= d_status_w;
      res_count_q  <= d_count_w;
      res_phys_q   <= '0;
    end
    if (cmd_i.cnt_step) begin
      idx_q <= idx_q + 1'b1;
      if (free_here_w) cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.grab_init) begin
      idx_q <= '0;
    end
    if (cmd_i.grab_step) begin
      idx_q <= idx_q + 1'b1;
      if (free_here_w) pg_q <= pg_q + 1'b1;
    end
    if (cmd_i.oom) begin
      res_status_q <= ST_OOM;
    end
    if (cmd_i.drop_clr) begin
      pg_q <= pg_q + 1'b1;
    end
    if (cmd_i.xl_fin) begin
      res_phys_q <= (PHYS_W'(rd_data_q) << sh_q) + PHYS_W'(addr_q[11:0] & mask_q);
    end
    if (cmd_i.commit_grow || (cmd_i.commit_drop && op_q == OP_RESIZE)) begin
      res_count_q <= need_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_used_q <= '0;
      present_q    <= '0;
      for (int i = 0; i < PROCS; i++) held_q[i] <= '0;
    end else begin
      if (cmd_i.grab_step && free_here_w) begin
        frame_used_q[idx_q[FRAME_W-1:0]] <= 1'b1;
      end
      if (cmd_i.drop_clr) begin
        frame_used_q[rd_data_q] <= 1'b0;
      end
      if (cmd_i.commit_grow) begin
        present_q[pid_q] <= 1'b1;
        held_q[pid_q]    <= need_q;
      end
      if (cmd_i.commit_drop) begin
        if (op_q == OP_FINISH) begin
          present_q[pid_q] <= 1'b0;
          held_q[pid_q]    <= '0;
        end else begin
          held_q[pid_q] <= need_q;
        end
      end
    end
  end

  assign status_o           = res_status_q;
  assign physical_address_o = res_phys_q;
  assign page_count_o       = res_count_q;
endmodule
`default_nettype wire

>>> hdl/page_frame_allocator_with_tables_core.sv
// Top level: stream ports, configuration registers and the result register.
// An item that needs no walk responds straight from the decision; translate reads the
// table and then forms the address; shrink and finish read and clear each page freed;
// a create or grow first counts free frames below the limit and, if there are enough,
// takes frames in a first-fit pass. One item is in work at a time; the next is taken
// the cycle after the result transfer. Reset clears the frame bitmap, the table present
// bits and page counts at once and loads the configuration reset values; no sweep.
`default_nettype none
module page_frame_allocator_with_tables_core import pfa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // opcode[1:0], pid[4:2], size_bytes[24:5], logical_address[40:25], zeros
  input  wire logic [IN_W-1:0]    s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // status[2:0], physical_address[20:3], page_count[25:21], zeros
  output logic [OUT_W-1:0]        m_axis_tdata,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [LIMIT_W-1:0] cfg_data_i
);
  logic [SHIFT_W-1:0] page_shift_q;
  logic [LIMIT_W-1:0] frame_limit_q;
  logic               out_valid_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [PHYS_W-1:0]  out_phys_q;
  logic [CNT_W-1:0]   out_count_q;
  logic               idle_w;
  logic               in_xfer_w;
  dp_cmd_t            cmd_w;
  dp_sts_t            sts_w;
  logic [STAT_W-1:0]  dp_status_w;
  logic [PHYS_W-1:0]  dp_phys_w;
  logic [CNT_W-1:0]   dp_count_w;

  // Configuration writes are always taken; software writes only while idle, a rule the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q  <= SHIFT_RESET;
      frame_limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PAGE_SHIFT:  page_shift_q  <= cfg_data_i[SHIFT_W-1:0];
        CFG_FRAME_LIMIT: frame_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // An item is taken only when the sequencer is idle and no result waits.
  assign s_axis_tready = idle_w && !out_valid_q;
  assign in_xfer_w     = s_axis_tvalid && s_axis_tready;

  pfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer_w),
    .sts_i   (sts_w),
    .cmd_o   (cmd_w),
    .idle_o  (idle_w)
  );

  pfa_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd_w),
    .sts_o              (sts_w),
    .opcode_i           (s_axis_tdata[1:0]),
    .pid_i              (s_axis_tdata[4:2]),
    .size_bytes_i       (s_axis_tdata[24:5]),
    .logical_address_i  (s_axis_tdata[40:25]),
    .page_shift_i       (page_shift_q),
    .frame_limit_i      (frame_limit_q),
    .status_o           (dp_status_w),
    .physical_address_o (dp_phys_w),
    .page_count_o       (dp_count_w)
  );

  // Result register: loaded when the sequencer finishes, held until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_w.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_w.finish) begin
      out_status_q <= dp_status_w;
      out_phys_q   <= dp_phys_w;
      out_count_q  <= dp_count_w;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_count_q, out_phys_q, out_status_q};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer_w |=> !s_axis_tready) else $error("item taken while busy");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_status_q <= ST_EXISTS) else $error("bad status code");
  a_phys_only_xlate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_DONE) |-> out_phys_q == '0)
    else $error("address on failed operation");
  a_finish_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_w.finish |-> !out_valid_q) else $error("result overwritten");
endmodule
`default_nettype wire

>>> tb/tb_page_frame_allocator_with_tables_core.sv
// Testbench for the page frame allocator: directed table, then random traffic.
`timescale 1ns / 1ps
`default_nettype none
module tb_page_frame_allocator_with_tables_core;
  import pfa_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [LIMIT_W-1:0] cfg_data_i = '0;

  page_frame_allocator_with_tables_core DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PHYS_W-1:0] phys;
    logic [CNT_W-1:0]  count;
  } alloc_result_t;

  // Predictor state: a shadow of the frame bitmap, tables and registers.
  logic [SHIFT_W-1:0] shadow_shift;
  logic [LIMIT_W-1:0] shadow_limit;
  logic               shadow_used [FRAMES];
  logic [FRAME_W-1:0] shadow_frame [PROCS][MAX_PAGES];
  int unsigned        shadow_held [PROCS];
  logic               shadow_present [PROCS];

  alloc_result_t pending_results[$];
  int   error_count = 0;
  int   item_count = 0;
  int   result_count = 0;
  bit   rx_hold = 1'b0;
  bit   rx_calm = 1'b0;
  bit   tx_calm = 1'b0;
  int   status_seen [6];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch after %0d results: %s got %0d expected %0d",
             result_count, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned used_shift();
    if (shadow_shift < SHIFT_MIN) return SHIFT_MIN;
    if (shadow_shift > SHIFT_MAX) return SHIFT_MAX;
    return shadow_shift;
  endfunction

  function automatic int unsigned used_limit();
    return (shadow_limit < FRAMES) ? shadow_limit : FRAMES;
  endfunction

  function automatic int unsigned free_frames();
    int unsigned n;
    n = 0;
    for (int i = 0; i < used_limit(); i++) if (!shadow_used[i]) n++;
    return n;
  endfunction

  // Maps pages first..last-1 of a slot onto the lowest free frames.
  task automatic map_pages(input int p, input int unsigned first, input int unsigned last);
    int unsigned f;
    f = 0;
    for (int unsigned pg = first; pg < last; pg++) begin
      while (f < used_limit() && shadow_used[f]) f++;
      shadow_used[f] = 1'b1;
      shadow_frame[p][pg] = f[FRAME_W-1:0];
    end
  endtask

  task automatic unmap_pages(input int p, input int unsigned first, input int unsigned last);
    for (int unsigned pg = first; pg < last; pg++) shadow_used[shadow_frame[p][pg]] = 1'b0;
  endtask

  function automatic void reset_shadow();
    shadow_shift = SHIFT_RESET;
    shadow_limit = LIMIT_RESET;
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    foreach (shadow_held[i]) begin
      shadow_held[i] = 0;
      shadow_present[i] = 1'b0;
    end
  endfunction

  // Works out the result of one operation and updates the shadow state.
  task automatic predict_operation(input logic [OP_W-1:0] op, input logic [PID_W-1:0] p,
                                   input logic [SIZE_W-1:0] size,
                                   input logic [ADDR_W-1:0] addr,
                                   output alloc_result_t r);
    int unsigned sh, need, held, cur, pg;
    sh = used_shift();
    need = (size + (1 << sh) - 1) >> sh;
    held = shadow_present[p] ? shadow_held[p] : 0;
    r = '0;
    if (op == OP_CREATE) begin
      if (shadow_present[p]) begin
        r.status = ST_EXISTS;
        r.count = CNT_W'(held);
      end else if (need > MAX_PAGES || free_frames() < need) begin
        r.status = ST_OOM;
      end else begin
        map_pages(p, 0, need);
        shadow_present[p] = 1'b1;
        shadow_held[p] = need;
        r.status = ST_DONE;
        r.count = CNT_W'(need);
      end
    end else if (!shadow_present[p]) begin
      r.status = ST_NO_TABLE;
    end else if (op == OP_RESIZE) begin
      cur = held << sh;
      r.count = CNT_W'(held);
      if (size == cur) begin
        r.status = ST_NO_CHANGE;
      end else if (size > cur) begin
        if (need > MAX_PAGES || free_frames() < need - held) begin
          r.status = ST_OOM;
        end else begin
          map_pages(p, held, need);
          shadow_held[p] = need;
          r.count = CNT_W'(need);
        end
      end else begin
        unmap_pages(p, need, held);
        shadow_held[p] = need;
        r.count = CNT_W'(need);
      end
    end else if (op == OP_XLATE) begin
      pg = addr >> sh;
      r.count = CNT_W'(held);
      if (pg >= held) r.status = ST_UNMAPPED;
      else r.phys = PHYS_W'((shadow_frame[p][pg] << sh) + (addr & ((1 << sh) - 1)));
    end else begin
      unmap_pages(p, 0, held);
      shadow_present[p] = 1'b0;
      shadow_held[p] = 0;
    end
  endtask

  // Sends one operation, predicting its result at the moment of transfer.
  // Valid drops only while the sender idles or pauses, so back-to-back items keep it high.
  task automatic send_operation(input logic [OP_W-1:0] op, input logic [PID_W-1:0] p,
                                input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    while (!tx_calm && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= {7'd0, addr, size, p, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_operation(op, p, size, addr, r);
    pending_results.push_back(r);
    item_count++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Registers change only with the block idle.
  task automatic write_register(input logic idx, input logic [LIMIT_W-1:0] value);
    drain_results();
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_PAGE_SHIFT) shadow_shift = value[SHIFT_W-1:0];
    else shadow_limit = value;
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        alloc_result_t got;
        got = {m_axis_tdata[2:0], m_axis_tdata[20:3], m_axis_tdata[25:21]};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", got.status, 0);
        end else begin
          alloc_result_t want;
          want = pending_results.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.phys != want.phys) report_mismatch("physical_address", got.phys, want.phys);
          if (got.count != want.count) report_mismatch("page_count", got.count, want.count);
          if (want.status < 6) status_seen[want.status]++;
        end
        result_count++;
      end
      m_axis_tready <= !rx_hold && (rx_calm || $urandom_range(99) >= 33);
    end
  end

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [PID_W-1:0]  pid;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    bit                known;
    alloc_result_t     want;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    '{OP_XLATE,  3'd0, 20'd0,       16'd0,      1, '{ST_NO_TABLE, 18'd0, 5'd0}},
    '{OP_RESIZE, 3'd7, 20'd5,       16'd0,      1, '{ST_NO_TABLE, 18'd0, 5'd0}},
    '{OP_FINISH, 3'd2, 20'd0,       16'd0,      1, '{ST_NO_TABLE, 18'd0, 5'd0}},
    '{OP_CREATE, 3'd0, 20'hFFFFF,   16'd0,      1, '{ST_OOM,      18'd0, 5'd0}},
    '{OP_CREATE, 3'd0, 20'd0,       16'd0,      1, '{ST_DONE,     18'd0, 5'd0}},
    '{OP_CREATE, 3'd0, 20'd1,       16'd0,      1, '{ST_EXISTS,   18'd0, 5'd0}},
    '{OP_XLATE,  3'd0, 20'd0,       16'd0,      1, '{ST_UNMAPPED, 18'd0, 5'd0}},
    '{OP_RESIZE, 3'd0, 20'd0,       16'd0,      1, '{ST_NO_CHANGE,18'd0, 5'd0}},
    '{OP_RESIZE, 3'd0, 20'd100,     16'd0,      1, '{ST_DONE,     18'd0, 5'd4}},
    '{OP_CREATE, 3'd7, 20'd512,     16'd0,      1, '{ST_DONE,     18'd0, 5'd16}},
    '{OP_XLATE,  3'd7, 20'd0,       16'd511,    1, '{ST_DONE,     18'd639, 5'd16}},
    '{OP_XLATE,  3'd0, 20'd0,       16'd37,     1, '{ST_DONE,     18'd37, 5'd4}},
    '{OP_XLATE,  3'd7, 20'd0,       16'hFFFF,   1, '{ST_UNMAPPED, 18'd0, 5'd16}},
    '{OP_RESIZE, 3'd7, 20'd513,     16'd0,      1, '{ST_OOM,      18'd0, 5'd16}},
    '{OP_RESIZE, 3'd7, 20'd500,     16'd0,      0, '{ST_DONE,     18'd0, 5'd0}},
    '{OP_RESIZE, 3'd7, 20'd33,      16'd0,      0, '{ST_DONE,     18'd0, 5'd0}},
    '{OP_CREATE, 3'd3, 20'd480,     16'd0,      0, '{ST_DONE,     18'd0, 5'd0}},
    '{OP_XLATE,  3'd3, 20'd0,       16'd470,    0, '{ST_DONE,     18'd0, 5'd0}},
    '{OP_FINISH, 3'd7, 20'd0,       16'd0,      1, '{ST_DONE,     18'd0, 5'd0}},
    '{OP_FINISH, 3'd0, 20'd0,       16'd0,      1, '{ST_DONE,     18'd0, 5'd0}},
    '{OP_FINISH, 3'd3, 20'd0,       16'd0,      1, '{ST_DONE,     18'd0, 5'd0}}
  };

  // One random operation on any slot, with sizes mostly up to just over a full table.
  task automatic random_operation();
    logic [OP_W-1:0]   op;
    logic [PID_W-1:0]  p;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    int unsigned sh;
    sh = used_shift();
    op = OP_W'($urandom_range(3));
    p = PID_W'($urandom_range(PROCS - 1));
    case ($urandom_range(9))
      0: size = SIZE_W'($urandom);
      1: size = SIZE_W'(shadow_held[p] << sh);
      default: size = SIZE_W'($urandom_range(MAX_PAGES * (1 << sh) + 2));
    endcase
    if ($urandom_range(9) == 0) addr = ADDR_W'($urandom);
    else addr = ADDR_W'($urandom_range((shadow_held[p] + 1) * (1 << sh)));
    if (op == OP_FINISH && $urandom_range(2) != 0) op = OP_XLATE;
    send_operation(op, p, size, addr);
  endtask

  initial begin
    reset_shadow();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_operation(directed_rows[i].op, directed_rows[i].pid, directed_rows[i].size,
                     directed_rows[i].addr);
      if (directed_rows[i].known) pending_results[$] = directed_rows[i].want;
    end

    // Sender pauses until every expected result has arrived.
    drain_results();

    // Receiver holds off while the sender keeps offering items.
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      repeat (6) random_operation();
    join

    // Phases across register settings, extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_register(CFG_PAGE_SHIFT, 7'd3); write_register(CFG_FRAME_LIMIT, 7'd64); end
        1: begin write_register(CFG_PAGE_SHIFT, 7'd12); write_register(CFG_FRAME_LIMIT, 7'd1); end
        2: begin write_register(CFG_PAGE_SHIFT, 7'd0); write_register(CFG_FRAME_LIMIT, 7'd0); end
        3: begin write_register(CFG_PAGE_SHIFT, 7'd15); write_register(CFG_FRAME_LIMIT, 7'd127); end
        4: begin write_register(CFG_PAGE_SHIFT, 7'd5); write_register(CFG_FRAME_LIMIT, 7'd20); end
        5: begin write_register(CFG_PAGE_SHIFT, 7'd4); write_register(CFG_FRAME_LIMIT, 7'd48); end
        6: begin write_register(CFG_PAGE_SHIFT, 7'h7F); write_register(CFG_FRAME_LIMIT, 7'd64); end
        default: begin write_register(CFG_PAGE_SHIFT, 7'd6); write_register(CFG_FRAME_LIMIT, 7'd33); end
      endcase
      tx_calm = (phase == 4);
      rx_calm = (phase == 4);
      repeat (103) random_operation();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    drain_results();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d operations over 8 register settings; %0d results checked.",
             item_count, result_count);
    $display("Status mix: done %0d, no table %0d, oom %0d, unmapped %0d, same %0d, exists %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Allow far more time than the slowest item plus stalls needs.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
